// ----- src/bdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types and constants shared by the button debouncer with long-press detection.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    localparam int unsigned CFG_ADDR_W  = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IN_DATA_W   = 8;
    localparam int unsigned OUT_DATA_W  = 16;
    localparam int unsigned SEC_CNT_W   = 8;
    localparam int unsigned CHANGE_W    = 17;
    localparam int unsigned TICK_W      = 16;

    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;

    localparam t_cfg_addr CFG_DEBOUNCE_TICKS = 8'd0;
    localparam t_cfg_addr CFG_SECOND_TICKS   = 8'd1;
    localparam t_cfg_addr CFG_HOLD_LIMIT     = 8'd2;
    localparam t_cfg_addr CFG_IDLE_LEVEL     = 8'd3;

    localparam logic [TICK_W-1:0]    RST_DEBOUNCE_TICKS = 16'd50;
    localparam logic [TICK_W-1:0]    RST_SECOND_TICKS   = 16'd1000;
    localparam logic [SEC_CNT_W-1:0] RST_HOLD_LIMIT     = 8'd10;
    localparam logic                 RST_IDLE_LEVEL     = 1'b1;

    localparam logic [CHANGE_W-1:0]  CHANGE_MAX  = '1;
    localparam logic [TICK_W-1:0]    TICK_MAX    = '1;
    localparam logic [SEC_CNT_W-1:0] SEC_CNT_MAX = '1;

    typedef struct packed {
        logic [TICK_W-1:0]    debounce_ticks;
        logic [TICK_W-1:0]    second_ticks;
        logic [SEC_CNT_W-1:0] hold_limit;
        logic                 idle_level;
    } t_cfg;

    typedef struct packed {
        logic                 is_held;
        logic [SEC_CNT_W-1:0] held_seconds;
        logic                 reset_event;
        logic                 second_event;
        logic                 release_event;
        logic                 press_event;
        logic                 stable_level;
    } t_result;

endpackage

// ----- src/bdlp_core.sv -----
// ----------------------------------------------------------------------------
// bdlp_core
// Debounce and hold-timing state with its one-tick update.
// ----------------------------------------------------------------------------
module bdlp_core
    import bdlp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_en,
    input  logic    i_pin_level,
    output t_result o_res
);

    logic                 r_last_raw, n_last_raw;
    logic                 r_debounced, n_debounced;
    logic [CHANGE_W-1:0]  r_since_change, n_since_change;
    logic                 r_holding, n_holding;
    logic [TICK_W-1:0]    r_since_second, n_since_second;
    logic [SEC_CNT_W-1:0] r_seconds, n_seconds;

    logic                 take;
    logic                 press;
    logic                 release_ev;
    logic                 sec_ev;
    logic                 rst_ev;
    logic [TICK_W-1:0]    ss_mid;
    logic [SEC_CNT_W-1:0] cnt_mid;

    always_comb begin
        n_last_raw = i_pin_level;

        if (i_pin_level != r_last_raw) begin
            n_since_change = '0;
        end else if (r_since_change != CHANGE_MAX) begin
            n_since_change = r_since_change + 1'b1;
        end else begin
            n_since_change = r_since_change;
        end

        take = (n_since_change > {1'b0, i_cfg.debounce_ticks}) &&
               (r_debounced != i_pin_level);
        n_debounced = take ? i_pin_level : r_debounced;

        press      = take && (i_pin_level != i_cfg.idle_level) && !r_holding;
        release_ev = take && (i_pin_level == i_cfg.idle_level) && r_holding;

        if (press) begin
            n_holding = 1'b1;
        end else if (release_ev) begin
            n_holding = 1'b0;
        end else begin
            n_holding = r_holding;
        end

        if (press) begin
            ss_mid  = '0;
            cnt_mid = '0;
        end else begin
            ss_mid  = (r_holding && r_since_second != TICK_MAX) ?
                      r_since_second + 1'b1 : r_since_second;
            cnt_mid = r_seconds;
        end

        sec_ev = n_holding && (ss_mid >= i_cfg.second_ticks);
        rst_ev = 1'b0;
        n_since_second = ss_mid;
        n_seconds      = cnt_mid;
        if (sec_ev) begin
            n_since_second = '0;
            if (cnt_mid != SEC_CNT_MAX) begin
                n_seconds = cnt_mid + 1'b1;
                rst_ev    = (n_seconds == i_cfg.hold_limit);
            end
        end

        o_res.stable_level  = n_debounced;
        o_res.press_event   = press;
        o_res.release_event = release_ev;
        o_res.second_event  = sec_ev;
        o_res.reset_event   = rst_ev;
        o_res.held_seconds  = n_seconds;
        o_res.is_held       = n_holding;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw     <= RST_IDLE_LEVEL;
            r_debounced    <= RST_IDLE_LEVEL;
            r_since_change <= CHANGE_MAX;
            r_holding      <= 1'b0;
            r_since_second <= '0;
            r_seconds      <= '0;
        end else if (i_en) begin
            r_last_raw     <= n_last_raw;
            r_debounced    <= n_debounced;
            r_since_change <= n_since_change;
            r_holding      <= n_holding;
            r_since_second <= n_since_second;
            r_seconds      <= n_seconds;
        end
    end

endmodule

// ----- src/bdlp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bdlp_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module bdlp_cfg_regs
    import bdlp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_addr             i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg, n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                CFG_DEBOUNCE_TICKS: n_cfg.debounce_ticks = i_cfg_data[TICK_W-1:0];
                CFG_SECOND_TICKS:   n_cfg.second_ticks   = i_cfg_data[TICK_W-1:0];
                CFG_HOLD_LIMIT:     n_cfg.hold_limit     = i_cfg_data[SEC_CNT_W-1:0];
                CFG_IDLE_LEVEL:     n_cfg.idle_level     = i_cfg_data[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= RST_DEBOUNCE_TICKS;
            r_cfg.second_ticks   <= RST_SECOND_TICKS;
            r_cfg.hold_limit     <= RST_HOLD_LIMIT;
            r_cfg.idle_level     <= RST_IDLE_LEVEL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- src/button_debounce_long_press.sv -----
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Button debouncer with press/release, hold-second and long-press events.
// ----------------------------------------------------------------------------
// Each input item is one millisecond tick carrying the raw button level; each
// item yields exactly one result item. The block takes one item per clock
// unless result-side backpressure stalls it: the item is held in an input
// register, the debounce and hold counters update in compare-and-increment
// logic, and the result waits in an output register. Either register moves on
// as soon as the next stage frees, so the block holds at most two items and
// backpressure on the result side stalls the input side only once both
// registers are full.
module button_debounce_long_press
    import bdlp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // tick items in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // [0] pin_level, [7:1] zero
    // result items out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] stable_level, [1] press_event, [2] release_event, [3] second_event,
    // [4] reset_event, [12:5] held_seconds, [13] is_held, [15:14] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    t_cfg    cfg;
    t_result res;

    logic    r_in_vld;
    logic    r_in_pin;
    logic    r_out_vld;
    t_result r_out;
    logic    advance;

    bdlp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign advance         = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_vld || advance;

    bdlp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_en        (r_in_vld && advance),
        .i_pin_level (r_in_pin),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_pin <= i_s_axis_tdata[0];
        end
        if (advance && r_in_vld) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out};

`ifndef SYNTHESIS
    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |=> r_in_vld && $stable(r_in_pin))
        else $error("pending input item lost under backpressure");

    a_press_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.press_event |-> r_out.is_held && !r_out.release_event)
        else $error("press result without an active hold");

    a_release_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.release_event |-> !r_out.is_held && !r_out.second_event)
        else $error("release result with hold still counting");

    a_reset_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.reset_event |->
            r_out.second_event && r_out.held_seconds == cfg.hold_limit)
        else $error("reset event off the hold limit");
`endif

endmodule

// ----- test/button_debounce_long_press_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_tb
// Self-checking bench for the button debouncer with long-press detection.
// ----------------------------------------------------------------------------
// Streams millisecond tick items carrying a raw button level into the block
// and compares every result item, field by field, with a cycle-free model of
// the debounce and hold-second counters kept here. The run starts with short
// hand-made sequences: bounce at reset settings, zero debounce and zero second
// length, idle level changed with no effect on the current state, count
// saturation at 255, and a short press held off by the largest tick settings.
// It then feeds randomized press/release sequences with contact bounce and
// noise under several register settings, with random stalls on both sides,
// one long output hold-off and full drains between settings.
// ----------------------------------------------------------------------------
module button_debounce_long_press_tb;
    import bdlp_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned HOLD_OFF_CYCLES = 80;
    localparam int unsigned MAX_REPORTS     = 40;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;   // [0] pin_level, [7:1] zero
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [0] stable_level, [1] press_event, [2] release_event, [3] second_event,
    // [4] reset_event, [12:5] held_seconds, [13] is_held, [15:14] zero
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    button_debounce_long_press dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // debouncer model state
    t_cfg                 model_cfg;
    logic                 last_pin;
    logic                 level;
    logic [CHANGE_W-1:0]  pin_age;
    logic                 holding;
    logic [TICK_W-1:0]    hold_age;
    logic [SEC_CNT_W-1:0] held_secs;

    logic    tick_queue[$];
    t_result expected_results[$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_off_req = 0;
    int unsigned hold_off_seen = 0;
    int unsigned rx_hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned ticks_sent = 0;
    int unsigned results_checked = 0;
    int unsigned presses = 0;
    int unsigned releases = 0;
    int unsigned seconds_seen = 0;
    int unsigned long_presses = 0;
    int unsigned settings_used = 0;

    t_result want;
    t_result got;

    function automatic t_result advance_tick(input logic pin);
        t_result r;
        r = '0;
        if (pin != last_pin) begin
            pin_age = '0;
        end else if (pin_age != CHANGE_MAX) begin
            pin_age = pin_age + 1'b1;
        end
        if (holding && hold_age != TICK_MAX) begin
            hold_age = hold_age + 1'b1;
        end
        if (pin_age > model_cfg.debounce_ticks && level != pin) begin
            level = pin;
            if (level != model_cfg.idle_level && !holding) begin
                hold_age  = '0;
                held_secs = '0;
                holding   = 1'b1;
                r.press_event = 1'b1;
            end
            if (level == model_cfg.idle_level && holding) begin
                holding = 1'b0;
                r.release_event = 1'b1;
            end
        end
        if (holding && hold_age >= model_cfg.second_ticks) begin
            r.second_event = 1'b1;
            if (held_secs != SEC_CNT_MAX) begin
                held_secs = held_secs + 1'b1;
                if (held_secs == model_cfg.hold_limit) begin
                    r.reset_event = 1'b1;
                end
            end
            hold_age = '0;
        end
        last_pin = pin;
        r.stable_level = level;
        r.held_seconds = held_secs;
        r.is_held      = holding;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input int unsigned seen,
                               input int unsigned wanted);
        if (seen != wanted) begin
            report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                      results_checked, name, seen, wanted));
        end
    endtask

    // tick item driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.push_back(advance_tick(i_s_axis_tdata[0]));
                ticks_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (tick_queue.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {{(IN_DATA_W-1){1'b0}}, tick_queue.pop_front()};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result item with no expectation pending");
                end else begin
                    want = expected_results.pop_front();
                    got  = t_result'(o_m_axis_tdata[$bits(t_result)-1:0]);
                    check_field("stable_level", got.stable_level, want.stable_level);
                    check_field("press_event", got.press_event, want.press_event);
                    check_field("release_event", got.release_event, want.release_event);
                    check_field("second_event", got.second_event, want.second_event);
                    check_field("reset_event", got.reset_event, want.reset_event);
                    check_field("held_seconds", got.held_seconds, want.held_seconds);
                    check_field("is_held", got.is_held, want.is_held);
                    check_field("padding", o_m_axis_tdata[OUT_DATA_W-1:$bits(t_result)], 0);
                    results_checked++;
                    presses      += want.press_event;
                    releases     += want.release_event;
                    seconds_seen += want.second_event;
                    long_presses += want.reset_event;
                end
            end
            if (hold_off_req != hold_off_seen) begin
                hold_off_seen   <= hold_off_req;
                rx_hold_left    <= HOLD_OFF_CYCLES;
                i_m_axis_tready <= 1'b0;
            end else if (rx_hold_left != 0) begin
                rx_hold_left    <= rx_hold_left - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_results.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_addr idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEBOUNCE_TICKS: model_cfg.debounce_ticks = val;
            CFG_SECOND_TICKS:   model_cfg.second_ticks   = val;
            CFG_HOLD_LIMIT:     model_cfg.hold_limit     = val[SEC_CNT_W-1:0];
            CFG_IDLE_LEVEL:     model_cfg.idle_level     = val[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input int unsigned debounce, input int unsigned second,
                                input int unsigned limit, input int unsigned idle);
        write_reg(CFG_DEBOUNCE_TICKS, CFG_DATA_W'(debounce));
        write_reg(CFG_SECOND_TICKS, CFG_DATA_W'(second));
        write_reg(CFG_HOLD_LIMIT, CFG_DATA_W'(limit));
        write_reg(CFG_IDLE_LEVEL, CFG_DATA_W'(idle));
        @(negedge i_clk);
        settings_used++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (tick_queue.size() != 0 || i_s_axis_tvalid || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic queue_run(input logic pin, input int unsigned count);
        repeat (count) tick_queue.push_back(pin);
    endtask

    // press/release sequences with contact bounce, plus some raw noise
    task automatic queue_segment(input int unsigned count);
        int unsigned queued;
        int unsigned k;
        int unsigned span;
        logic        rest;
        queued = 0;
        rest   = model_cfg.idle_level;
        span   = model_cfg.debounce_ticks + 2
                 + model_cfg.second_ticks * (model_cfg.hold_limit + 2);
        while (queued < count) begin
            if ($urandom_range(9, 0) == 0) begin
                k = $urandom_range(8, 1);
                repeat (k) tick_queue.push_back(1'($urandom_range(1, 0)));
                queued += k;
            end else begin
                k = $urandom_range(3, 0);
                repeat (k) begin
                    queue_run(~rest, 1);
                    queue_run(rest, 1);
                end
                queued += 2 * k;
                k = $urandom_range(span, 1);
                queue_run(~rest, k);
                queued += k;
                k = $urandom_range(2, 0);
                repeat (k) begin
                    queue_run(rest, 1);
                    queue_run(~rest, 1);
                end
                queued += 2 * k;
                k = $urandom_range(model_cfg.debounce_ticks + 4, 1);
                queue_run(rest, k);
                queued += k;
            end
        end
    endtask

    initial begin
        model_cfg.debounce_ticks = RST_DEBOUNCE_TICKS;
        model_cfg.second_ticks   = RST_SECOND_TICKS;
        model_cfg.hold_limit     = RST_HOLD_LIMIT;
        model_cfg.idle_level     = RST_IDLE_LEVEL;
        last_pin  = RST_IDLE_LEVEL;
        level     = RST_IDLE_LEVEL;
        pin_age   = CHANGE_MAX;
        holding   = 1'b0;
        hold_age  = '0;
        held_secs = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // bounce at reset settings never gets through
        tx_idle_pct = 24;
        rx_idle_pct = 81;
        queue_run(1'b0, 2);
        queue_run(1'b1, 1);
        queue_run(1'b0, 3);
        queue_run(1'b1, 2);
        wait_drained();

        // zero debounce, zero-length seconds, no long-press event
        program_regs(0, 0, 0, 1);
        queue_run(1'b1, 1);
        queue_run(1'b0, 5);
        queue_run(1'b1, 1);
        queue_run(1'b0, 1);
        queue_run(1'b1, 3);
        wait_drained();

        // idle level flipped: no effect until the next debounced change,
        // then a press that runs the count to saturation
        program_regs(1, 1, 255, 0);
        queue_run(1'b0, 3);
        queue_run(1'b1, 262);
        queue_run(1'b0, 3);
        wait_drained();

        // largest tick settings: a short press that debounce keeps out
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        program_regs(65535, 65535, 1, 0);
        queue_run(1'b1, 40);
        queue_run(1'b0, 4);
        wait_drained();

        for (int unsigned phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 24; rx_idle_pct = 81; end
                1: begin tx_idle_pct = 81; rx_idle_pct = 24; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            repeat (2) begin
                program_regs($urandom_range(6, 0), $urandom_range(10, 0),
                             $urandom_range(8, 0), $urandom_range(1, 0));
                if (phase == 2 && hold_off_req == 0) begin
                    hold_off_req++;
                end
                queue_segment(140);
                wait_drained();
            end
        end

        repeat (10) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        end
        $display("Checked %0d results from %0d ticks under %0d register settings.",
                 results_checked, ticks_sent, settings_used);
        $display("Seen: %0d presses, %0d releases, %0d hold seconds, %0d long presses.",
                 presses, releases, seconds_seen, long_presses);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
